// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the word repeat run encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== hw/rtl/wrr_pkg.sv =====
// Package of the word repeat run encoder: widths, queue sizing and the result type.
package wrr_pkg;

    localparam int WORD_WIDTH        = 32;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_WIDTH    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_WIDTH    = $clog2(FIFO_DEPTH + 1);

    typedef logic [WORD_WIDTH-1:0]     word_t;
    typedef logic [FIFO_PTR_WIDTH-1:0] fifo_ptr_t;
    typedef logic [FIFO_CNT_WIDTH-1:0] fifo_cnt_t;

    typedef struct packed {
        word_t payload;
        logic  is_run;
        logic  transfer_done;
        logic  last_of_item;
    } result_t;

endpackage

// ===== hw/rtl/wrr_in_if.sv =====
// Input word channel: valid/ready handshake with the word and its end-of-transfer flag.
interface wrr_in_if
    import wrr_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t data_word;
    logic  end_of_transfer;

    modport source (output valid, output data_word, output end_of_transfer, input ready);
    modport sink   (input valid, input data_word, input end_of_transfer, output ready);
endinterface

// ===== hw/rtl/wrr_out_if.sv =====
// Result channel: valid/ready handshake with a literal word or a repeat count.
interface wrr_out_if
    import wrr_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t payload;
    logic  is_run;
    logic  transfer_done;
    logic  last_of_item;

    modport source (output valid, output payload, output is_run, output transfer_done,
                    output last_of_item, input ready);
    modport sink   (input valid, input payload, input is_run, input transfer_done,
                    input last_of_item, output ready);
endinterface

// ===== hw/rtl/word_repeat_run_encoder.sv =====
// Top level of the word repeat run encoder: compare/count stage and result queue.
//
// Usage:
//   words  - input channel, one 32-bit word per transfer, end_of_transfer marks the
//            final word of a buffer transfer.
//   codes  - result channel. A word that differs from the last literal comes out as
//            a literal (is_run 0). Repeats of the last literal are counted and come
//            out as one count result (is_run 1, payload = repeat count) when a
//            differing word arrives (ahead of its literal), when the transfer ends,
//            or when the counter reaches 2^COUNT_WIDTH - 1.
//   A word yields zero, one or two results; last_of_item flags the last of them.
// Results are registered in the result queue and leave it on codes in arrival order.
// Throughput: one word per cycle while the receiver takes one result per cycle;
//   a word that yields two results grows the queue by one. The rate is set
//   by the 4-entry result queue, which accepts a word only with two free slots.
// Reset: last literal and repeat count clear to zero, queue empties. Both also
//   return to zero after every end_of_transfer word.
// Stall: when codes.ready is low the queue holds its results; words.ready drops
//   once fewer than two slots are free, so nothing is lost.
module word_repeat_run_encoder
    import wrr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    wrr_in_if.sink        words,
    wrr_out_if.source     codes
);

`include "assert_macros.svh"

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Encoder state.
    word_t                  prev_literal_reg, prev_literal_next;
    logic [COUNT_WIDTH-1:0] repeat_count_reg, repeat_count_next;

    // Result queue.
    result_t   fifo_reg [FIFO_DEPTH];
    fifo_ptr_t head_reg, head_next;
    fifo_ptr_t tail_reg, tail_next;
    fifo_cnt_t count_reg, count_next;

    logic                   accept;
    logic                   pop;
    logic                   is_repeat;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [1:0]             push_n;
    result_t                res_a;
    result_t                res_b;

    // Take a word only with room for the two results it may cause.
    assign words.ready = (count_reg <= fifo_cnt_t'(FIFO_DEPTH - 2));
    assign accept      = words.valid && words.ready;
    assign pop         = codes.valid && codes.ready;

    assign is_repeat = (words.data_word == prev_literal_reg);
    assign count_inc = repeat_count_reg + COUNT_WIDTH'(1);

    // Decide results and next state for the incoming word.
    always_comb
    begin
        res_a             = '0;
        res_b             = '0;
        push_n            = 2'd0;
        prev_literal_next = prev_literal_reg;
        repeat_count_next = repeat_count_reg;

        if (accept)
        begin
            if (is_repeat)
            begin
                repeat_count_next = count_inc;
                if (words.end_of_transfer)
                begin
                    res_a  = '{payload: WORD_WIDTH'(count_inc), is_run: 1'b1,
                               transfer_done: 1'b1, last_of_item: 1'b1};
                    push_n = 2'd1;
                end
                else if (count_inc == COUNT_MAX)
                begin
                    // Counter full: flush the run and start a fresh count.
                    res_a             = '{payload: WORD_WIDTH'(count_inc), is_run: 1'b1,
                                          transfer_done: 1'b0, last_of_item: 1'b1};
                    push_n            = 2'd1;
                    repeat_count_next = '0;
                end
            end
            else
            begin
                if (repeat_count_reg != '0)
                begin
                    // Pending run goes out ahead of the new literal.
                    res_a  = '{payload: WORD_WIDTH'(repeat_count_reg), is_run: 1'b1,
                               transfer_done: 1'b0, last_of_item: 1'b0};
                    res_b  = '{payload: words.data_word, is_run: 1'b0,
                               transfer_done: words.end_of_transfer, last_of_item: 1'b1};
                    push_n = 2'd2;
                end
                else
                begin
                    res_a  = '{payload: words.data_word, is_run: 1'b0,
                               transfer_done: words.end_of_transfer, last_of_item: 1'b1};
                    push_n = 2'd1;
                end
                prev_literal_next = words.data_word;
                repeat_count_next = '0;
            end

            if (words.end_of_transfer)
            begin
                prev_literal_next = '0;
                repeat_count_next = '0;
            end
        end
    end

    // Advance queue pointers.
    always_comb
    begin
        tail_next  = tail_reg + fifo_ptr_t'(push_n);
        head_next  = pop ? head_reg + fifo_ptr_t'(1) : head_reg;
        count_next = count_reg + fifo_cnt_t'(push_n) - fifo_cnt_t'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_literal_reg <= '0;
            repeat_count_reg <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
        end
        else
        begin
            prev_literal_reg <= prev_literal_next;
            repeat_count_reg <= repeat_count_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
        end
    end

    // Queue storage: write up to two results per cycle, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[tail_reg] <= res_a;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[tail_reg + fifo_ptr_t'(1)] <= res_b;
        end
    end

    // Drive the result channel from the queue head.
    assign codes.valid         = (count_reg != '0);
    assign codes.payload       = fifo_reg[head_reg].payload;
    assign codes.is_run        = fifo_reg[head_reg].is_run;
    assign codes.transfer_done = fifo_reg[head_reg].transfer_done;
    assign codes.last_of_item  = fifo_reg[head_reg].last_of_item;

    `ASSERT_ALWAYS(a_fifo_bound, count_reg <= fifo_cnt_t'(FIFO_DEPTH), "result queue overflow")
    `ASSERT_CLK(a_end_clears, accept && words.end_of_transfer |=> prev_literal_reg == '0 && repeat_count_reg == '0, "state not cleared after transfer end")
    `ASSERT_CLK(a_run_nonzero, codes.valid && codes.is_run |-> codes.payload != '0, "count result with zero count")
    `ASSERT_CLK(a_done_is_last, codes.valid && codes.transfer_done |-> codes.last_of_item, "transfer end result not last of its word")

endmodule
